### rtl/armt_pkg.sv
`timescale 1ns / 1ps
package armt_pkg;
	localparam int MAX_RANGES_DEF = 32;
	localparam int PAGE_SHIFT_DEF = 12;
	localparam int ADDR_BITS_DEF  = 48;
	localparam int ATTR_BITS      = 32;
	localparam int MODE_BITS      = 32;
	localparam int STATUS_BITS    = 2;
	localparam int REG_IDX_BITS   = 2;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK       = 2'd0,
		ST_INVAL    = 2'd1,
		ST_NOSPACE  = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_SPACE_BASE   = 2'd0,
		REG_SPACE_TOP    = 2'd1,
		REG_WINDOW_START = 2'd2,
		REG_WINDOW_END   = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_MAP   = 1'b0,
		CMD_UNMAP = 1'b1
	} cmd_t;
endpackage

### rtl/armt_if.sv
`timescale 1ns / 1ps
interface armt_in_if #(parameter int ADDR_BITS = 48);
	import armt_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [ADDR_BITS-1:0] address;
	logic [ADDR_BITS-1:0] length;
	logic [ATTR_BITS-1:0] attributes;
	logic [MODE_BITS-1:0] mode_bits;
	modport source (output valid, command, address, length, attributes, mode_bits,
		input ready);
	modport sink (input valid, command, address, length, attributes, mode_bits,
		output ready);
endinterface

interface armt_out_if #(parameter int ADDR_BITS = 48);
	import armt_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [ADDR_BITS-1:0]   result_address;
	modport source (output valid, status, result_address, input ready);
	modport sink (input valid, status, result_address, output ready);
endinterface

interface armt_cfg_if #(parameter int ADDR_BITS = 48);
	import armt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [REG_IDX_BITS-1:0] index;
	logic [ADDR_BITS-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/armt_ram.sv
`timescale 1ns / 1ps
module armt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/address_region_map_table.sv
`timescale 1ns / 1ps
// address region map table
// channels: cfg (index, data) writes one of four address registers; it is always ready
// and must only be written while no command is in flight. in carries one command word
// (map or unmap, address, length, attributes, mode bits); out returns one word per
// command with status and result address.
// the table lives in one ram; a sequencer scans it one entry at a time.
// a command scans the table entry by entry, and an insert or remove then moves the
// entries behind the slot one by one.
// a map with automatic placement makes one extra scan for the overlap test.
// in is not ready while a command is in work or its result waits in the output
// register; a stalled receiver holds the result and blocks the next command.
// reset returns to idle, clears the config registers and the entry count, which empties the table; no clearing pass.
module address_region_map_table #(
	parameter int MAX_RANGES = armt_pkg::MAX_RANGES_DEF,
	parameter int PAGE_SHIFT = armt_pkg::PAGE_SHIFT_DEF,
	parameter int ADDR_BITS  = armt_pkg::ADDR_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	armt_cfg_if.sink cfg,
	armt_in_if.sink  in_ch,
	armt_out_if.source out_ch
);
	import armt_pkg::*;

	localparam int IW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int EW = 2 * ADDR_BITS + ATTR_BITS + MODE_BITS;
	localparam logic [ADDR_BITS-1:0] PGMASK = ADDR_BITS'((64'd1 << PAGE_SHIFT) - 64'd1);
	localparam logic [ADDR_BITS-1:0] AMASK  = '1;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_CHECK = 10'b0000000010,
		S_RD    = 10'b0000000100,
		S_EVAL  = 10'b0000001000,
		S_PLACE = 10'b0000010000,
		S_OVRD  = 10'b0000100000,
		S_SHRD  = 10'b0001000000,
		S_SHWR  = 10'b0010000000,
		S_FIN   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;
	state_t state_q;

	logic [ADDR_BITS-1:0] base_q, top_q, wst_q, wend_q;
	logic                 cmd_q;
	logic [ADDR_BITS-1:0] va_q, len_q, sz_q, end_q, fa_q;
	logic [ATTR_BITS-1:0] attr_q;
	logic [MODE_BITS-1:0] mode_q;
	logic                 found_q;
	logic [CW-1:0]        cnt_q, i_q, pos_q;
	logic [STATUS_BITS-1:0] st_q;
	logic [ADDR_BITS-1:0] res_q;
	logic                 hit_q;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic [ADDR_BITS-1:0] e_start, e_end;

	armt_ram #(.WIDTH(EW), .DEPTH(MAX_RANGES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);
	assign e_start = rdata[EW-1 -: ADDR_BITS];
	assign e_end   = rdata[EW-ADDR_BITS-1 -: ADDR_BITS];

	assign cfg.ready      = 1'b1;
	assign in_ch.ready    = (state_q == S_IDLE);
	assign out_ch.valid   = (state_q == S_OUT);
	assign out_ch.status  = st_q;
	assign out_ch.result_address = res_q;

	function automatic logic fits(input logic [ADDR_BITS-1:0] a, n, lim);
		fits = (n <= lim) && (a <= lim - n);
	endfunction

	// one shared compare path per scan step
	logic f_win, f_in_win, f_gap;
	assign f_in_win = (e_start >= wst_q) && (e_end <= wend_q);
	assign f_win    = fits(fa_q, len_q, wend_q);
	assign f_gap    = fits(fa_q, len_q, e_start);

	logic [ADDR_BITS-1:0] va_al, sz_c;
	assign va_al = va_q & ~PGMASK;
	assign sz_c  = (len_q + PGMASK) & ~PGMASK;

	logic moving_up;
	assign moving_up = (cmd_q == CMD_MAP);

	always_comb begin
		we    = 1'b0;
		waddr = i_q[IW-1:0];
		wdata = rdata;
		raddr = i_q[IW-1:0];
		if (state_q == S_SHRD) begin
			raddr = moving_up ? IW'(i_q - CW'(1)) : IW'(i_q + CW'(1));
		end
		if (state_q == S_SHWR) begin
			we = 1'b1;
		end
		if (state_q == S_FIN && cmd_q == CMD_MAP && st_q == ST_OK) begin
			we    = 1'b1;
			waddr = pos_q[IW-1:0];
			wdata = {va_q, end_q, attr_q, mode_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q <= '0; top_q <= '0; wst_q <= '0; wend_q <= '0;
			cnt_q <= '0; i_q <= '0; pos_q <= '0; st_q <= ST_OK;
			res_q <= '0; found_q <= 1'b0;
			hit_q <= 1'b0; cmd_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (reg_idx_t'(cfg.index))
					REG_SPACE_BASE:   base_q <= cfg.data;
					REG_SPACE_TOP:    top_q  <= cfg.data;
					REG_WINDOW_START: wst_q  <= cfg.data;
					REG_WINDOW_END:   wend_q <= cfg.data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						cmd_q  <= in_ch.command;
						va_q   <= in_ch.address;
						len_q  <= in_ch.length;
						attr_q <= in_ch.attributes;
						mode_q <= in_ch.mode_bits;
						fa_q   <= wst_q;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					i_q <= '0; found_q <= 1'b0; hit_q <= 1'b0;
					pos_q <= cnt_q; st_q <= ST_OK; res_q <= '0;
					sz_q <= sz_c;
					if (cmd_q == CMD_MAP) begin
						if (len_q == '0 || attr_q == '0) begin
							st_q <= ST_INVAL; state_q <= S_OUT;
						end else if (va_q != '0 && (va_q < base_q || !fits(va_q, len_q, top_q)))
						begin
							st_q <= ST_INVAL; state_q <= S_OUT;
						end else if (va_q == '0) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_PLACE;
						end
					end else begin
						if (va_q == '0 || len_q == '0 || (va_q & PGMASK) != '0 ||
							va_q < base_q || va_q >= top_q || !fits(va_q, len_q, top_q) ||
							len_q > AMASK - PGMASK) begin
							st_q <= ST_INVAL; state_q <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (i_q >= cnt_q) begin
						if (cmd_q == CMD_UNMAP) begin
							st_q <= ST_NOTFOUND; state_q <= S_OUT;
						end else if (!fits(fa_q, len_q, wend_q)) begin
							st_q <= ST_NOSPACE; state_q <= S_OUT;
						end else begin
							va_q <= fa_q; state_q <= S_PLACE;
						end
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_RD;
					i_q <= i_q + CW'(1);
					if (cmd_q == CMD_UNMAP) begin
						if (va_q >= e_start && va_q <= e_end && sz_q <= e_end - va_q) begin
							state_q <= S_SHRD;
						end
					end else if (f_in_win) begin
						if (!f_win) begin
							st_q <= ST_NOSPACE; state_q <= S_OUT;
						end else if (f_gap) begin
							va_q <= fa_q; state_q <= S_PLACE;
						end else begin
							fa_q <= e_end;
						end
					end
				end
				S_PLACE: begin
					va_q <= va_al;
					if (len_q > AMASK - PGMASK || sz_q > AMASK - va_al) begin
						st_q <= ST_INVAL; state_q <= S_OUT;
					end else begin
						end_q <= va_al + sz_q;
						i_q <= '0; pos_q <= cnt_q;
						state_q <= S_OVRD;
						found_q <= 1'b1;
					end
				end
				S_OVRD: begin
					// found_q marks a read pending for index i_q
					if (found_q) begin
						found_q <= 1'b0;
						if (i_q >= cnt_q) begin
							if (cnt_q >= CW'(MAX_RANGES)) begin
								st_q <= ST_NOSPACE; state_q <= S_OUT;
							end else begin
								i_q <= cnt_q;
								state_q <= (pos_q < cnt_q) ? S_SHRD : S_FIN;
							end
						end
					end else begin
						found_q <= 1'b1;
						i_q <= i_q + CW'(1);
						if (va_q < e_end && end_q > e_start) begin
							st_q <= ST_INVAL; state_q <= S_OUT;
						end else if (e_start >= va_q && pos_q == cnt_q) begin
							pos_q <= i_q;
						end
					end
				end
				S_SHRD: begin
					if (cmd_q == CMD_UNMAP && !hit_q) begin
						hit_q <= 1'b1;
						i_q <= i_q - CW'(1);
					end
					if (moving_up ? (i_q <= pos_q) : (i_q + CW'(1) >= cnt_q
						&& !(!hit_q))) begin
						state_q <= S_FIN;
					end else if (moving_up || hit_q) begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					i_q <= moving_up ? i_q - CW'(1) : i_q + CW'(1);
					state_q <= S_SHRD;
				end
				S_FIN: begin
					if (cmd_q == CMD_MAP) begin
						cnt_q <= cnt_q + CW'(1);
						res_q <= va_q;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
